/* rtl/udpsf_pkg.sv */
// udp port steering filter: shared types, codes and constants
// no dependencies; imported by every module of the block
package udpsf_pkg;

   // default sizes, handed to the top level parameters
   localparam int PORT_ENTRIES_DEF = 64;
   localparam int QUEUES_DEF       = 64;
   localparam int MAX_FRAME_DEF    = 2047;

   // protocol constants
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam int          ETH_LEN        = 14;
   localparam int          IP_MIN_LEN     = 20;
   localparam int          UDP_LEN        = 8;
   localparam int          ETYPE_HI_POS   = 12;
   localparam int          ETYPE_LO_POS   = 13;
   localparam int          PROTO_POS      = ETH_LEN + 9;

   // job queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // register index (byte address bit 3)
   localparam logic CSR_SOCKET_MASK = 1'b0;

   typedef enum logic [2:0] {
      REASON_REDIRECT  = 3'd0,
      REASON_SHORT     = 3'd1,
      REASON_NOT_IPV4  = 3'd2,
      REASON_NOT_UDP   = 3'd3,
      REASON_UNLISTED  = 3'd4,
      REASON_NO_SOCKET = 3'd5
   } reason_type;

   typedef enum logic {
      OP_FRAME_BYTE  = 1'b0,
      OP_TABLE_WRITE = 1'b1
   } op_type;

   // one job: a table write or a frame to classify
   // port: dest port of the frame, or port for the slot
   // queue: rx queue of the frame, or slot index
   typedef struct packed {
      logic        is_write;
      reason_type  pre_reason;
      logic [15:0] port;
      logic [5:0]  queue;
      logic        entry_valid;
   } job_type;

endpackage

/* rtl/udpsf_front.sv */
// front part: accepts requests, parses frame headers, emits jobs
// depends on udpsf_pkg
module udpsf_front #(
   parameter int MAX_FRAME = udpsf_pkg::MAX_FRAME_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [7:0]        req_frame_byte,
   input  logic              req_last_byte,
   input  logic [5:0]        req_rx_queue,
   input  logic [5:0]        req_entry_index,
   input  logic [15:0]       req_entry_port,
   input  logic              req_entry_valid,
   output logic              push_o,
   output udpsf_pkg::job_type push_job_o,
   input  logic              full_i
);
   import udpsf_pkg::*;

   localparam int OFF_W = $clog2(MAX_FRAME + 1);

   logic [OFF_W-1:0] off_ff, off_in;
   logic [15:0]      etype_ff, etype_in;
   logic [3:0]       hw_ff, hw_in;
   logic [7:0]       proto_ff, proto_in;
   logic [15:0]      dport_ff, dport_in;

   logic             accept;
   logic             frame_byte;
   logic             storing;
   logic [OFF_W-1:0] udp_at;
   logic [OFF_W-1:0] udp_end;
   reason_type       pre_reason;

   assign req_ready  = !full_i;
   assign accept     = req_valid && req_ready;
   assign frame_byte = accept && (op_type'(req_op) == OP_FRAME_BYTE);
   assign storing    = off_ff < OFF_W'(MAX_FRAME);
   assign udp_at     = OFF_W'(ETH_LEN) + OFF_W'({hw_ff, 2'b00});

   // header capture for the current byte
   always_comb begin
      etype_in = etype_ff;
      hw_in    = hw_ff;
      proto_in = proto_ff;
      dport_in = dport_ff;
      off_in   = off_ff;
      if (storing) begin
         if (off_ff == OFF_W'(ETYPE_HI_POS) || off_ff == OFF_W'(ETYPE_LO_POS)) begin
            etype_in = {etype_ff[7:0], req_frame_byte};
         end
         if (off_ff == OFF_W'(ETH_LEN)) begin
            hw_in = req_frame_byte[3:0];
         end
         if (off_ff == OFF_W'(PROTO_POS)) begin
            proto_in = req_frame_byte;
         end
         if (off_ff > OFF_W'(ETH_LEN) &&
             (off_ff == udp_at + OFF_W'(2) || off_ff == udp_at + OFF_W'(3))) begin
            dport_in = {dport_ff[7:0], req_frame_byte};
         end
         off_in = off_ff + OFF_W'(1);
      end
   end

   // header checks that need no table lookup
   assign udp_end = OFF_W'(ETH_LEN + UDP_LEN) + OFF_W'({hw_in, 2'b00});

   always_comb begin
      priority if (off_in < OFF_W'(ETH_LEN)) begin
         pre_reason = REASON_SHORT;
      end else if (etype_in != ETHERTYPE_IPV4) begin
         pre_reason = REASON_NOT_IPV4;
      end else if (off_in < OFF_W'(ETH_LEN + IP_MIN_LEN)) begin
         pre_reason = REASON_SHORT;
      end else if (proto_in != PROTO_UDP) begin
         pre_reason = REASON_NOT_UDP;
      end else if (off_in < udp_end) begin
         pre_reason = REASON_SHORT;
      end else begin
         pre_reason = REASON_REDIRECT;
      end
   end

   // job to the queue: table writes and finished frames
   always_comb begin
      push_o = accept && ((op_type'(req_op) == OP_TABLE_WRITE) || req_last_byte);
      push_job_o.is_write    = (op_type'(req_op) == OP_TABLE_WRITE);
      push_job_o.entry_valid = req_entry_valid;
      if (op_type'(req_op) == OP_TABLE_WRITE) begin
         push_job_o.pre_reason = REASON_REDIRECT;
         push_job_o.port       = req_entry_port;
         push_job_o.queue      = req_entry_index;
      end else begin
         push_job_o.pre_reason = pre_reason;
         push_job_o.port       = dport_in;
         push_job_o.queue      = req_rx_queue;
      end
   end

   // per-frame state, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         etype_ff <= '0;
         hw_ff    <= '0;
         proto_ff <= '0;
         dport_ff <= '0;
      end else if (frame_byte) begin
         if (req_last_byte) begin
            off_ff   <= '0;
            etype_ff <= '0;
            hw_ff    <= '0;
            proto_ff <= '0;
            dport_ff <= '0;
         end else begin
            off_ff   <= off_in;
            etype_ff <= etype_in;
            hw_ff    <= hw_in;
            proto_ff <= proto_in;
            dport_ff <= dport_in;
         end
      end
   end

`ifndef ASSERT_OFF
   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (frame_byte && req_last_byte) |=> (off_ff == '0 && dport_ff == '0))
      else $error("frame state not cleared after last byte");
`endif

endmodule

/* rtl/udpsf_fifo.sv */
// job queue between front and back parts
// depends on udpsf_pkg
module udpsf_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_i,
   input  udpsf_pkg::job_type push_job_i,
   output logic               full_o,
   input  logic               pop_i,
   output udpsf_pkg::job_type head_o,
   output logic               empty_o
);
   import udpsf_pkg::*;

   job_type               mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, wr_in;
   logic [FIFO_PTR_W-1:0] rd_ff, rd_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full_o  = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty_o = (cnt_ff == '0);
   assign head_o  = mem[rd_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;

   // pointers and fill count
   always_comb begin
      wr_in  = do_push ? wr_ff + FIFO_PTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + FIFO_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_job_i;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_i && full_o))
      else $error("job pushed into a full queue");
`endif

endmodule

/* rtl/udpsf_back.sv */
// back part: port table, table match, final reason and result register
// depends on udpsf_pkg
module udpsf_back #(
   parameter int PORT_ENTRIES = udpsf_pkg::PORT_ENTRIES_DEF,
   parameter int QUEUES       = udpsf_pkg::QUEUES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  udpsf_pkg::job_type head_i,
   input  logic               empty_i,
   output logic               pop_o,
   input  logic [63:0]        socket_mask_i,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_redirect,
   output logic [5:0]         rsp_target_queue,
   output logic [2:0]         rsp_reason
);
   import udpsf_pkg::*;

   localparam int IDX_W = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;

   logic [15:0]       ports_ff [PORT_ENTRIES];
   logic [PORT_ENTRIES-1:0] valid_ff;
   logic [PORT_ENTRIES-1:0] hit;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_redirect_ff;
   logic [5:0]        rsp_queue_ff;
   reason_type        rsp_reason_ff;

   logic              out_free;
   logic              table_we;
   logic [IDX_W-1:0]  widx;
   logic              listed;
   reason_type        reason;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop_o    = !empty_i && (head_i.is_write || out_free);
   assign table_we = pop_o && head_i.is_write && (32'(head_i.queue) < PORT_ENTRIES);
   assign widx     = IDX_W'(head_i.queue);

   // parallel compare over the table
   always_comb begin
      for (int i = 0; i < PORT_ENTRIES; i++) begin
         hit[i] = valid_ff[i] && (ports_ff[i] == head_i.port);
      end
   end
   assign listed = |hit;

   // final reason
   always_comb begin
      priority if (head_i.pre_reason != REASON_REDIRECT) begin
         reason = head_i.pre_reason;
      end else if (!listed) begin
         reason = REASON_UNLISTED;
      end else if (!(32'(head_i.queue) < QUEUES) || !socket_mask_i[head_i.queue]) begin
         reason = REASON_NO_SOCKET;
      end else begin
         reason = REASON_REDIRECT;
      end
   end

   // table valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (table_we) begin
         valid_ff[widx] <= head_i.entry_valid;
      end
   end

   // table ports
   always_ff @(posedge clock) begin
      if (table_we) begin
         ports_ff[widx] <= head_i.port;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_o && !head_i.is_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_o && !head_i.is_write) begin
         rsp_redirect_ff <= (reason == REASON_REDIRECT);
         rsp_queue_ff    <= (reason == REASON_REDIRECT) ? head_i.queue : 6'd0;
         rsp_reason_ff   <= reason;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_redirect     = rsp_redirect_ff;
   assign rsp_target_queue = rsp_queue_ff;
   assign rsp_reason       = rsp_reason_ff;

`ifndef ASSERT_OFF
   a_redirect_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_redirect_ff == (rsp_reason_ff == REASON_REDIRECT)))
      else $error("redirect flag disagrees with reason");

   a_table_write_lands: assert property (@(posedge clock) disable iff (reset)
      table_we |=> (valid_ff[$past(widx)] == $past(head_i.entry_valid)))
      else $error("port table write lost");

   a_pass_has_no_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_redirect_ff) |-> (rsp_queue_ff == 6'd0))
      else $error("passed frame carries a target queue");
`endif

endmodule

/* rtl/udp_port_steering_filter_core.sv */
// udp port steering filter, top level: socket mask register and the front/back split
// depends on udpsf_pkg, udpsf_front, udpsf_fifo, udpsf_back
//
// Request channel (req_*): one frame byte per request (op 0) with a last-byte
// flag and the receive queue, or a port table write (op 1). Result channel
// (rsp_*): one result per frame, issued for the request that carries the last
// byte: redirect flag, target queue and reason code. Table writes give no result.
// The last byte's job is written into the job queue, and its result into the output register.
// Throughput: one request per cycle while req_ready is high; the port match is a
// combinational parallel compare over all table slots in the back part.
// A four-entry job queue sits between the header parser and the matcher, and
// the result sits in an output register: while rsp_ready is low the parser
// keeps taking bytes until the queue fills, then req_ready drops.
// The APB port holds the 64-bit socket mask at address 0; write it only idle.
// Reset (synchronous, active high) clears the frame state, the queue, the
// result valid flag, the socket mask and every table valid bit; no clearing pass.
module udp_port_steering_filter_core #(
   parameter int PORT_ENTRIES = udpsf_pkg::PORT_ENTRIES_DEF,
   parameter int QUEUES       = udpsf_pkg::QUEUES_DEF,
   parameter int MAX_FRAME    = udpsf_pkg::MAX_FRAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   input  logic [5:0]  req_rx_queue,
   input  logic [5:0]  req_entry_index,
   input  logic [15:0] req_entry_port,
   input  logic        req_entry_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_redirect,
   output logic [5:0]  rsp_target_queue,
   output logic [2:0]  rsp_reason,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import udpsf_pkg::*;

   job_type     push_job;
   job_type     head;
   logic        push;
   logic        full;
   logic        pop;
   logic        empty;
   logic [63:0] mask_ff, mask_in;
   logic        mask_sel;

   // socket mask register
   assign pready   = 1'b1;
   assign mask_sel = (paddr[3] == CSR_SOCKET_MASK);
   assign mask_in  = (psel && penable && pwrite && mask_sel) ? pwdata : mask_ff;
   assign prdata   = mask_sel ? mask_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // header parser
   udpsf_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_frame_byte  (req_frame_byte),
      .req_last_byte   (req_last_byte),
      .req_rx_queue    (req_rx_queue),
      .req_entry_index (req_entry_index),
      .req_entry_port  (req_entry_port),
      .req_entry_valid (req_entry_valid),
      .push_o          (push),
      .push_job_o      (push_job),
      .full_i          (full)
   );

   // job queue
   udpsf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push),
      .push_job_i (push_job),
      .full_o     (full),
      .pop_i      (pop),
      .head_o     (head),
      .empty_o    (empty)
   );

   // table match and result
   udpsf_back #(
      .PORT_ENTRIES (PORT_ENTRIES),
      .QUEUES       (QUEUES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_i           (head),
      .empty_i          (empty),
      .pop_o            (pop),
      .socket_mask_i    (mask_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_redirect     (rsp_redirect),
      .rsp_target_queue (rsp_target_queue),
      .rsp_reason       (rsp_reason)
   );

endmodule

/* tb/sv/tb.sv */
// testbench for udp_port_steering_filter_core: bursty request traffic, stalled results,
// an in-order predictor of the parser and matcher, apb writes of the socket mask
// depends on udpsf_pkg and the rtl of the block
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import udpsf_pkg::*;

   localparam int SLOTS        = PORT_ENTRIES_DEF;
   localparam int QUEUE_COUNT  = QUEUES_DEF;
   localparam int FRAME_CAP    = MAX_FRAME_DEF;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [3:0] MASK_ADDR = {CSR_SOCKET_MASK, 3'b000};
   localparam logic [15:0] HOT_PORTS [4] = '{16'd0, 16'hFFFF, 16'd53, 16'd4789};

   typedef logic [7:0] frame_bytes_type [$];

   typedef struct packed {
      logic        redirect;
      logic [5:0]  target_queue;
      reason_type  reason;
   } steer_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [7:0]  req_frame_byte;
   logic        req_last_byte;
   logic [5:0]  req_rx_queue;
   logic [5:0]  req_entry_index;
   logic [15:0] req_entry_port;
   logic        req_entry_valid;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_redirect;
   logic [5:0]  rsp_target_queue;
   logic [2:0]  rsp_reason;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   // predictor state
   logic [63:0]      socket_mask;
   logic [16:0]      port_slots [SLOTS];
   int               seen_len;
   logic [15:0]      seen_etype;
   logic [3:0]       seen_ihl;
   logic [7:0]       seen_proto;
   logic [15:0]      seen_dport;
   steer_result_type expected_steer [$];
   steer_result_type head_steer;

   int mismatches;
   int items_sent;
   int burst_left;
   int rcv_mode;
   int rcv_left;

   udp_port_steering_filter_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_frame_byte   (req_frame_byte),
      .req_last_byte    (req_last_byte),
      .req_rx_queue     (req_rx_queue),
      .req_entry_index  (req_entry_index),
      .req_entry_port   (req_entry_port),
      .req_entry_valid  (req_entry_valid),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_redirect     (rsp_redirect),
      .rsp_target_queue (rsp_target_queue),
      .rsp_reason       (rsp_reason),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < 40) begin
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      end
      mismatches++;
   endtask

   // classification of the frame just closed
   function automatic reason_type classify_frame(logic [5:0] q);
      int udp_at;
      bit listed;
      udp_at = ETH_LEN + 4 * int'(seen_ihl);
      listed = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (port_slots[i][16] && port_slots[i][15:0] == seen_dport) listed = 1'b1;
      end
      if (seen_len < ETH_LEN) return REASON_SHORT;
      if (seen_etype != ETHERTYPE_IPV4) return REASON_NOT_IPV4;
      if (seen_len < ETH_LEN + IP_MIN_LEN) return REASON_SHORT;
      if (seen_proto != PROTO_UDP) return REASON_NOT_UDP;
      if (seen_len < udp_at + UDP_LEN) return REASON_SHORT;
      if (!listed) return REASON_UNLISTED;
      if (int'(q) >= QUEUE_COUNT || !socket_mask[q]) return REASON_NO_SOCKET;
      return REASON_REDIRECT;
   endfunction

   // predictor: one accepted request
   function automatic void steer_predict(op_type op, logic [7:0] b, logic last, logic [5:0] q,
                                         logic [5:0] idx, logic [15:0] port, logic ev);
      int pos;
      int udp_at;
      steer_result_type r;
      if (op == OP_TABLE_WRITE) begin
         if (int'(idx) < SLOTS) port_slots[idx] = {ev, port};
         return;
      end
      // header capture, offsets saturate at the frame cap
      if (seen_len < FRAME_CAP) begin
         pos = seen_len;
         udp_at = ETH_LEN + 4 * int'(seen_ihl);
         if (pos == ETYPE_HI_POS || pos == ETYPE_LO_POS) seen_etype = {seen_etype[7:0], b};
         if (pos == ETH_LEN) seen_ihl = b[3:0];
         if (pos == PROTO_POS) seen_proto = b;
         if (pos > ETH_LEN && (pos == udp_at + 2 || pos == udp_at + 3)) begin
            seen_dport = {seen_dport[7:0], b};
         end
         seen_len = pos + 1;
      end
      if (!last) return;
      r.reason = classify_frame(q);
      r.redirect = (r.reason == REASON_REDIRECT);
      r.target_queue = r.redirect ? q : 6'd0;
      expected_steer.push_back(r);
      seen_len = 0;
      seen_etype = '0;
      seen_ihl = '0;
      seen_proto = '0;
      seen_dport = '0;
   endfunction

   function automatic logic [15:0] pick_port();
      int sel;
      sel = $urandom_range(0, 3);
      if (sel < 2) return port_slots[$urandom_range(0, SLOTS - 1)][15:0];
      if (sel == 2) return HOT_PORTS[$urandom_range(0, 3)];
      return 16'($urandom);
   endfunction

   // frame of len bytes with the header fields placed where the length allows
   function automatic frame_bytes_type build_frame(int len, logic [15:0] etype, int ihl,
                                                  logic [7:0] proto, logic [15:0] dport);
      frame_bytes_type f;
      int udp_at;
      logic [3:0] ver;
      udp_at = ETH_LEN + 4 * ihl;
      ver = 4'($urandom);
      for (int i = 0; i < len; i++) f.push_back(8'($urandom));
      if (len > ETYPE_HI_POS) f[ETYPE_HI_POS] = etype[15:8];
      if (len > ETYPE_LO_POS) f[ETYPE_LO_POS] = etype[7:0];
      if (len > ETH_LEN) f[ETH_LEN] = {ver, 4'(ihl)};
      if (len > PROTO_POS) f[PROTO_POS] = proto;
      if (len > udp_at + 2) f[udp_at + 2] = dport[15:8];
      if (len > udp_at + 3) f[udp_at + 3] = dport[7:0];
      return f;
   endfunction

   // one request, sent in bursts with random gaps
   task automatic send_request(op_type op, logic [7:0] b, logic last, logic [5:0] q,
                               logic [5:0] idx, logic [15:0] port, logic ev);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_frame_byte  <= b;
      req_last_byte   <= last;
      req_rx_queue    <= q;
      req_entry_index <= idx;
      req_entry_port  <= port;
      req_entry_valid <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      steer_predict(op, b, last, q, idx, port, ev);
   endtask

   task automatic write_slot(logic [5:0] idx, logic [15:0] port, logic ev);
      send_request(OP_TABLE_WRITE, 8'($urandom), 1'($urandom), 6'($urandom), idx, port, ev);
   endtask

   // a frame, with an optional table write before byte write_at
   task automatic send_frame(frame_bytes_type f, logic [5:0] q, int write_at,
                             logic [5:0] w_idx, logic [15:0] w_port, logic w_valid);
      int n;
      n = f.size();
      for (int i = 0; i < n; i++) begin
         if (i == write_at) write_slot(w_idx, w_port, w_valid);
         send_request(OP_FRAME_BYTE, f[i], i == n - 1, (i == n - 1) ? q : 6'($urandom),
                      6'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   task automatic send_udp(int len, int ihl, logic [15:0] dport, logic [5:0] q);
      send_frame(build_frame(len, ETHERTYPE_IPV4, ihl, PROTO_UDP, dport), q, -1,
                 '0, '0, 1'b0);
   endtask

   // hold off until every result is back and the table writes have drained
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_steer.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [63:0] data);
      wait_drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MASK_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      socket_mask = data;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= MASK_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== socket_mask) report_mismatch("socket mask readback", prdata, socket_mask);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // result side stalls in stretches of its own
   always @(posedge clock) begin
      if (rcv_left == 0) begin
         rcv_mode <= $urandom_range(0, 3);
         rcv_left <= $urandom_range(4, 80);
      end else begin
         rcv_left <= rcv_left - 1;
      end
      case (rcv_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= rcv_left[3];
      endcase
   end

   // compare each result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_steer.size() == 0) begin
            report_mismatch("result with no request", 64'(rsp_reason), 64'd0);
         end else begin
            head_steer = expected_steer.pop_front();
            if (rsp_redirect !== head_steer.redirect) begin
               report_mismatch("redirect", 64'(rsp_redirect), 64'(head_steer.redirect));
            end
            if (rsp_target_queue !== head_steer.target_queue) begin
               report_mismatch("target_queue", 64'(rsp_target_queue),
                               64'(head_steer.target_queue));
            end
            if (rsp_reason !== head_steer.reason) begin
               report_mismatch("reason", 64'(rsp_reason), 64'(head_steer.reason));
            end
         end
      end
   end

   // mask reads back zero, and an empty table lists no port
   task automatic test_reset_state();
      csr_read();
      send_udp(42, 5, 16'd53, 6'd5);
      send_udp(42, 5, 16'd0, 6'd0);
   endtask

   // length, ethertype, protocol and header length checks in order, then table match and socket mask cases
   task automatic test_header_checks();
      csr_write(64'hFFFF_FFFF_FFFF_FF7F);
      write_slot(6'd0, 16'd0, 1'b1);
      write_slot(6'd63, 16'hFFFF, 1'b1);
      write_slot(6'd10, 16'd53, 1'b1);
      write_slot(6'd11, 16'd53, 1'b1);
      send_udp(1, 5, 16'd0, 6'd0);
      send_udp(13, 5, 16'd0, 6'd0);
      send_udp(14, 5, 16'd0, 6'd0);
      send_frame(build_frame(14, 16'h86DD, 5, PROTO_UDP, 16'd0), 6'd0, -1, '0, '0, 1'b0);
      send_frame(build_frame(40, 16'h0801, 5, PROTO_UDP, 16'd0), 6'd0, -1, '0, '0, 1'b0);
      send_udp(33, 5, 16'd0, 6'd0);
      send_frame(build_frame(34, ETHERTYPE_IPV4, 5, 8'd6, 16'd0), 6'd0, -1, '0, '0, 1'b0);
      send_udp(34, 5, 16'd0, 6'd0);
      send_udp(41, 5, 16'd0, 6'd0);
      send_udp(42, 5, 16'd0, 6'd0);
      send_udp(42, 5, 16'hFFFF, 6'd63);
      send_udp(50, 5, 16'd53, 6'd7);
      send_udp(42, 5, 16'd54, 6'd8);
      // header length below five puts the udp header inside the ip header
      send_udp(34, 0, 16'd53, 6'd9);
      send_udp(34, 2, 16'd53, 6'd9);
      // header length fifteen
      send_udp(81, 15, 16'd53, 6'd1);
      send_udp(82, 15, 16'd53, 6'd1);
   endtask

   // table writes during a frame, removal and duplicate slots
   task automatic test_table_updates();
      send_frame(build_frame(42, ETHERTYPE_IPV4, 5, PROTO_UDP, 16'd54), 6'd3,
                 20, 6'd20, 16'd54, 1'b1);
      write_slot(6'd63, 16'hFFFF, 1'b0);
      send_udp(42, 5, 16'hFFFF, 6'd4);
      write_slot(6'd10, 16'd53, 1'b0);
      send_udp(42, 5, 16'd53, 6'd2);
      write_slot(6'd11, 16'd53, 1'b0);
      send_udp(42, 5, 16'd53, 6'd2);
      write_slot(6'd63, 16'hFFFF, 1'b1);
   endtask

   // frame longer than the offset counter saturates at
   task automatic test_long_frame();
      write_slot(6'd12, 16'd4789, 1'b1);
      send_udp(FRAME_CAP + 13, 5, 16'd4789, 6'd1);
   endtask

   // socket mask extremes
   task automatic test_socket_mask();
      csr_write(64'h0);
      csr_read();
      send_udp(42, 5, 16'd0, 6'd0);
      send_udp(42, 5, 16'd4789, 6'd63);
      csr_write(64'h8000_0000_0000_0000);
      csr_read();
      send_udp(42, 5, 16'hFFFF, 6'd63);
      send_udp(42, 5, 16'hFFFF, 6'd62);
      csr_write(64'hFFFF_FFFF_FFFF_FFFF);
      csr_read();
      send_udp(42, 5, 16'hFFFF, 6'd0);
   endtask

   // mostly well-formed udp frames with random content, plus noise and truncation
   task automatic test_random_traffic(int goal);
      logic [63:0] masks [5];
      int start_items;
      int phase_goal;
      int kind;
      int ihl;
      int need;
      int len;
      int write_at;
      logic [15:0] etype;
      logic [7:0] proto;
      masks[0] = {$urandom, $urandom};
      masks[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      masks[2] = 64'h5555_5555_5555_5555;
      masks[3] = 64'h0;
      masks[4] = {$urandom, $urandom} & {$urandom, $urandom};
      start_items = items_sent;
      for (int ph = 0; ph < 5; ph++) begin
         csr_write(masks[ph]);
         csr_read();
         phase_goal = start_items + goal * (ph + 1) / 5;
         while (items_sent < phase_goal) begin
            if ($urandom_range(0, 39) == 0) wait_drain();
            if ($urandom_range(0, 9) < 2) begin
               write_slot(6'($urandom), pick_port(), $urandom_range(0, 4) != 0);
            end else begin
               kind = $urandom_range(0, 19);
               ihl = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
               need = ETH_LEN + 4 * ihl + UDP_LEN;
               if (need < ETH_LEN + IP_MIN_LEN) need = ETH_LEN + IP_MIN_LEN;
               etype = ETHERTYPE_IPV4;
               proto = PROTO_UDP;
               len = need + $urandom_range(0, 8);
               case (kind)
                  13, 14: len = $urandom_range(1, need - 1);
                  15: begin
                     etype = 16'($urandom);
                     len = $urandom_range(1, 60);
                  end
                  16: begin
                     proto = 8'($urandom);
                     len = $urandom_range(14, 60);
                  end
                  17: begin
                     if ($urandom_range(0, 4) == 0) begin
                        len = $urandom_range(FRAME_CAP - 8, FRAME_CAP + 12);
                     end
                  end
                  18: begin
                     if ($urandom_range(0, 1) == 0) etype = 16'($urandom);
                     proto = 8'($urandom);
                     len = $urandom_range(1, 80);
                  end
                  default: ;
               endcase
               write_at = -1;
               if ($urandom_range(0, 7) == 0) write_at = $urandom_range(0, len - 1);
               send_frame(build_frame(len, etype, ihl, proto, pick_port()), 6'($urandom),
                          write_at, 6'($urandom), pick_port(), $urandom_range(0, 3) != 0);
            end
         end
      end
   endtask

   // run limit
   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_FRAME_BYTE;
      req_frame_byte = '0;
      req_last_byte = 1'b0;
      req_rx_queue = '0;
      req_entry_index = '0;
      req_entry_port = '0;
      req_entry_valid = 1'b0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatches = 0;
      items_sent = 0;
      burst_left = 0;
      rcv_mode = 0;
      rcv_left = 0;
      socket_mask = '0;
      for (int i = 0; i < SLOTS; i++) port_slots[i] = '0;
      seen_len = 0;
      seen_etype = '0;
      seen_ihl = '0;
      seen_proto = '0;
      seen_dport = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_header_checks();
      test_table_updates();
      test_long_frame();
      test_socket_mask();
      test_random_traffic(700);
      wait_drain();

      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/udpsf_pkg.sv
rtl/udpsf_front.sv
rtl/udpsf_fifo.sv
rtl/udpsf_back.sv
rtl/udp_port_steering_filter_core.sv
tb/sv/tb.sv
